// ----- sv/ids_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ids_pkg: shared constants and types for the iterative deepening search
// Sizes of the node and edge stores, and the layout of their entries.
// ----------------------------------------------------------------------------
package ids_pkg;

	// Widths of the item fields.
	localparam int FIELD_W    = 10;

	// Store sizes.
	localparam int NODE_COUNT = 1024;
	localparam int EDGE_COUNT = 4096;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int EDGE_W     = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
	localparam int CNT_W      = $clog2(EDGE_COUNT + 1);

	// Node levels saturate at the top of their range.
	localparam int LEVEL_W    = 10;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

	// Item kinds.
	localparam logic KIND_EDGE   = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	// Head of the outgoing edge list of one node.
	typedef struct packed {
		logic              valid;
		logic [EDGE_W-1:0] link;
	} head_t;

	// One stored edge: link to the next edge of the same parent and its target.
	typedef struct packed {
		logic              nvalid;
		logic [EDGE_W-1:0] link;
		logic [NODE_W-1:0] target;
	} edge_t;

	// True when a field value names an existing node.
	function automatic logic node_ok(input logic [FIELD_W-1:0] v);
		return (int'(v) < NODE_COUNT);
	endfunction

endpackage

// ----- sv/ids_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ids_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and returns the
// old contents when the same address is written in that cycle.
// ----------------------------------------------------------------------------
module ids_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/iterative_deepening_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_deepening_search: graph store with iterative deepening search
// Loads directed edges into per-node linked lists and answers reachability
// queries by depth-limited passes of growing limit.
// ----------------------------------------------------------------------------
// Usage
//   The item channel (item_valid / item_ready) carries one word per item.
//   kind = 0 loads the edge parent -> child; it produces no result; the head
//   read is followed by the list and level writes. An edge that arrives when
//   the edge store is full is dropped and sets the sticky capacity_overflow
//   flag.
//   kind = 1 searches from root for goal. The search first clears the two
//   frontier memories and marks the root, then runs one scan per limit. A
//   scan runs a check, reads the frontier bit of every node, reads the head
//   of each node in the frontier and walks each edge from it, and ends with
//   a closing step. There are at most deepest_level scans; a final check or
//   a scan that walks no edge ends the search, and the result is loaded.
//   The single read port of each store paces the search: every list step
//   waits on one RAM read.
//   The result channel (result_valid / result_ready) carries found and
//   capacity_overflow from an output register. A new item is accepted while a
//   result waits; a second search holds its result until the first is taken.
//   After reset the block sweeps the list heads and node levels to empty and
//   zero, with item_ready low throughout.
// ----------------------------------------------------------------------------
module iterative_deepening_search (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic                   kind,
	input  logic [ids_pkg::FIELD_W-1:0] parent,
	input  logic [ids_pkg::FIELD_W-1:0] child,
	input  logic [ids_pkg::FIELD_W-1:0] root,
	input  logic [ids_pkg::FIELD_W-1:0] goal,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic                   found,
	output logic                   capacity_overflow
);

	import ids_pkg::*;

	// Sequencer states.
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_LOAD  = 4'd2;
	localparam logic [3:0] S_ROOT  = 4'd3;
	localparam logic [3:0] S_CHECK = 4'd4;
	localparam logic [3:0] S_SCAN  = 4'd5;
	localparam logic [3:0] S_SCANW = 4'd6;
	localparam logic [3:0] S_HEAD  = 4'd7;
	localparam logic [3:0] S_EDGE  = 4'd8;
	localparam logic [3:0] S_END   = 4'd9;
	localparam logic [3:0] S_RES   = 4'd10;

	localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);
	localparam logic [CNT_W-1:0]  EDGE_FULL = CNT_W'(EDGE_COUNT);

	logic [3:0]         state_q;
	logic               init_q;
	logic [NODE_W-1:0]  n_q;
	logic [NODE_W-1:0]  par_q;
	logic [NODE_W-1:0]  chi_q;
	logic [NODE_W-1:0]  root_q;
	logic [NODE_W-1:0]  goal_q;
	logic [LEVEL_W-1:0] limit_q;
	logic [LEVEL_W-1:0] deepest_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               dropped_q;
	logic               sel_q;
	logic               any_q;
	logic               hit_q;
	logic               res_found_q;
	logic               result_valid_q;
	logic               found_q;
	logic               ovf_q;

	// Store ports.
	logic               head_we;
	logic [NODE_W-1:0]  head_waddr;
	head_t              head_wdata;
	logic [NODE_W-1:0]  head_raddr;
	head_t              head_rd;
	logic               level_we;
	logic [LEVEL_W-1:0] level_wdata;
	logic [NODE_W-1:0]  level_raddr;
	logic [LEVEL_W-1:0] level_rd;
	logic               edge_we;
	edge_t              edge_wdata;
	logic [EDGE_W-1:0]  edge_raddr;
	edge_t              edge_rd;
	logic               a_we;
	logic [NODE_W-1:0]  a_waddr;
	logic               a_wdata;
	logic               a_rd;
	logic               b_we;
	logic [NODE_W-1:0]  b_waddr;
	logic               b_wdata;
	logic               b_rd;

	logic               accept;
	logic               cur_rd;
	logic [LEVEL_W-1:0] lvl_inc;
	logic               last_node;

	assign accept     = item_valid && item_ready;
	assign item_ready = (state_q == S_IDLE);
	assign cur_rd     = sel_q ? b_rd : a_rd;
	assign lvl_inc    = (level_rd < LEVEL_MAX) ? level_rd + LEVEL_W'(1) : level_rd;
	assign last_node  = (n_q == NODE_LAST);

	assign result_valid      = result_valid_q;
	assign found             = found_q;
	assign capacity_overflow = ovf_q;

	// Store instances.
	ids_ram #(.WIDTH($bits(head_t)), .DEPTH(NODE_COUNT)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rd)
	);

	ids_ram #(.WIDTH(LEVEL_W), .DEPTH(NODE_COUNT)) u_level (
		.clk(clk), .we(level_we), .waddr(chi_q), .wdata(level_wdata),
		.raddr(level_raddr), .rdata(level_rd)
	);

	ids_ram #(.WIDTH($bits(edge_t)), .DEPTH(EDGE_COUNT)) u_edge (
		.clk(clk), .we(edge_we), .waddr(cnt_q[EDGE_W-1:0]), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rd)
	);

	ids_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_reach_a (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(n_q), .rdata(a_rd)
	);

	ids_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_reach_b (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(n_q), .rdata(b_rd)
	);

	// Address and write control for the stores.
	always_comb begin
		head_we     = 1'b0;
		head_waddr  = par_q;
		head_wdata  = '{valid: 1'b1, link: cnt_q[EDGE_W-1:0]};
		head_raddr  = n_q;
		level_we    = 1'b0;
		level_wdata = lvl_inc;
		level_raddr = NODE_W'(parent);
		edge_we     = 1'b0;
		edge_wdata  = '{nvalid: head_rd.valid, link: head_rd.link, target: chi_q};
		edge_raddr  = head_rd.link;
		a_we        = 1'b0;
		a_waddr     = n_q;
		a_wdata     = 1'b0;
		b_we        = 1'b0;
		b_waddr     = n_q;
		b_wdata     = 1'b0;
		case (state_q)
			S_CLEAR: begin
				head_we    = init_q;
				head_waddr = n_q;
				head_wdata = '{valid: 1'b0, link: '0};
				level_we    = init_q;
				level_wdata = '0;
				a_we = 1'b1;
				b_we = 1'b1;
			end
			S_IDLE: begin
				head_raddr = NODE_W'(parent);
			end
			S_LOAD: begin
				head_we  = 1'b1;
				edge_we  = 1'b1;
				level_we = 1'b1;
			end
			S_ROOT: begin
				a_we    = 1'b1;
				a_waddr = root_q;
				a_wdata = 1'b1;
			end
			S_SCAN: begin
				// Read the current frontier bit and clear it behind the read.
				a_we = !sel_q;
				b_we = sel_q;
			end
			S_EDGE: begin
				// Mark the target in the next frontier; stored targets are
				// always valid nodes.
				edge_raddr = edge_rd.link;
				a_we       = sel_q;
				a_waddr    = edge_rd.target;
				a_wdata    = 1'b1;
				b_we       = !sel_q;
				b_waddr    = edge_rd.target;
				b_wdata    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			init_q         <= 1'b1;
			n_q            <= '0;
			limit_q        <= '0;
			deepest_q      <= '0;
			cnt_q          <= '0;
			dropped_q      <= 1'b0;
			sel_q          <= 1'b0;
			any_q          <= 1'b0;
			hit_q          <= 1'b0;
			res_found_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (last_node) begin
						n_q     <= '0;
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_ROOT;
					end else begin
						n_q <= n_q + NODE_W'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_EDGE) begin
							if (node_ok(parent) && node_ok(child)) begin
								if (cnt_q == EDGE_FULL) begin
									dropped_q <= 1'b1;
								end else begin
									state_q <= S_LOAD;
								end
							end
						end else begin
							if (node_ok(root) && node_ok(goal)) begin
								n_q     <= '0;
								sel_q   <= 1'b0;
								limit_q <= '0;
								hit_q   <= (root == goal);
								state_q <= S_CLEAR;
							end else begin
								res_found_q <= 1'b0;
								state_q     <= S_RES;
							end
						end
					end
				end
				S_LOAD: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (deepest_q < lvl_inc) begin
						deepest_q <= lvl_inc;
					end
					state_q <= S_IDLE;
				end
				S_ROOT: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (hit_q) begin
						res_found_q <= 1'b1;
						state_q     <= S_RES;
					end else if (limit_q >= deepest_q) begin
						res_found_q <= 1'b0;
						state_q     <= S_RES;
					end else begin
						n_q     <= '0;
						any_q   <= 1'b0;
						hit_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					state_q <= S_SCANW;
				end
				S_SCANW, S_HEAD, S_EDGE: begin
					// Walk the list of a frontier node, or move to the next node.
					if (state_q == S_SCANW && cur_rd) begin
						state_q <= S_HEAD;
					end else if (state_q == S_HEAD && head_rd.valid) begin
						state_q <= S_EDGE;
					end else if (state_q == S_EDGE && edge_rd.nvalid) begin
						state_q <= S_EDGE;
					end else if (last_node) begin
						state_q <= S_END;
					end else begin
						n_q     <= n_q + NODE_W'(1);
						state_q <= S_SCAN;
					end
					if (state_q == S_EDGE) begin
						any_q <= 1'b1;
						if (edge_rd.target == goal_q) begin
							hit_q <= 1'b1;
						end
					end
				end
				S_END: begin
					if (!any_q) begin
						res_found_q <= 1'b0;
						state_q     <= S_RES;
					end else begin
						sel_q   <= !sel_q;
						limit_q <= limit_q + LEVEL_W'(1);
						state_q <= S_CHECK;
					end
				end
				S_RES: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item fields and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			par_q  <= NODE_W'(parent);
			chi_q  <= NODE_W'(child);
			root_q <= NODE_W'(root);
			goal_q <= NODE_W'(goal);
		end
		if (state_q == S_RES && (!result_valid_q || result_ready)) begin
			found_q <= res_found_q;
			ovf_q   <= dropped_q;
		end
	end

	// The edge count never passes the store size.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= EDGE_FULL)
		else $error("edge count beyond store size");

	// The overflow flag is sticky.
	a_drop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |=> dropped_q)
		else $error("overflow flag cleared");

	// A pass only starts below the deepest level.
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (limit_q < deepest_q))
		else $error("pass started at or beyond deepest level");

	// A loaded result carries the overflow flag of its time.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RES && (!result_valid_q || result_ready))
		|=> (result_valid && capacity_overflow == dropped_q))
		else $error("result not loaded as expected");

	// No item is taken while the stores are being swept.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !item_ready)
		else $error("item accepted during store sweep");

endmodule
